@@ src/percent_decoder_macros.svh @@
// Assertion macros shared by the percent decoder RTL.
// Used by pctd_dec and pctd_outq; expects clk and rst_n in scope.
`ifndef PERCENT_DECODER_MACROS_SVH
`define PERCENT_DECODER_MACROS_SVH

// Property checked on every edge outside reset.
`define PCTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define PCTD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ src/pctd_pkg.sv @@
// Types, constants and helpers for the percent decoder.
// No dependencies; imported by pctd_dec, pctd_outq and percent_decoder.
package pctd_pkg;

  localparam logic [7:0] PCT_CHAR = 8'h25;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTW = $clog2(QDEPTH);
  localparam int unsigned QCNTW = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       string_end;
    logic       run_last;
  } res_t;

  // up to two results produced by one item, r0 first
  typedef struct packed {
    logic [1:0] n;
    res_t       r1;
    res_t       r0;
  } push_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  // nibble value of a hex digit; letters have low nibble 1..6
  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    return (c <= 8'h39) ? c[3:0] : c[3:0] + 4'd9;
  endfunction

endpackage

@@ src/pctd_dec.sv @@
// Escape-decode state machine: phase and held digit, plus per-item results.
// Depends on pctd_pkg and percent_decoder_macros.svh.
`include "percent_decoder_macros.svh"

module pctd_dec (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        data,
  input  logic              last,
  output pctd_pkg::push_t   push
);
  import pctd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;

  logic       hx, pct, idle_path, to_digit;
  logic       emit_held, emit_comb, emit_b, emit_flush, have0, two;
  phase_t     phase_pre;
  logic [7:0] held_pre, comb_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

  always_comb begin
    hx        = is_hex(data);
    pct       = (data == PCT_CHAR);
    idle_path = 1'b0;
    to_digit  = 1'b0;
    emit_held = 1'b0;
    emit_comb = 1'b0;
    case (phase_r)
      PH_PCT: begin
        to_digit  = hx;
        idle_path = !hx;
      end
      PH_DIGIT: begin
        emit_comb = hx;
        emit_held = !hx;
        idle_path = !hx;
      end
      default: begin
        idle_path = 1'b1;
      end
    endcase

    emit_b     = idle_path && !pct;
    emit_flush = last && to_digit;
    comb_val   = {hex_nib(held_r), hex_nib(data)};

    if (to_digit) begin
      phase_pre = PH_DIGIT;
    end else if (idle_path && pct) begin
      phase_pre = PH_PCT;
    end else begin
      phase_pre = PH_IDLE;
    end
    if (to_digit) begin
      held_pre = data;
    end else if (phase_r == PH_DIGIT) begin
      held_pre = 8'd0;
    end else begin
      held_pre = held_r;
    end

    have0 = emit_held || emit_comb || emit_b || emit_flush;
    two   = emit_held && emit_b;

    // first result: broken/complete pair, plain byte, flushed digit, or bare end marker
    if (emit_held) begin
      push.r0.out_byte = held_r;
    end else if (emit_comb) begin
      push.r0.out_byte = comb_val;
    end else if (emit_b || emit_flush) begin
      push.r0.out_byte = data;
    end else begin
      push.r0.out_byte = 8'd0;
    end
    push.r0.has_byte   = have0;
    push.r0.string_end = last && !two;
    push.r0.run_last   = !two;

    // second result only when a broken pair is followed by a plain byte
    push.r1.out_byte   = data;
    push.r1.has_byte   = 1'b1;
    push.r1.string_end = last;
    push.r1.run_last   = 1'b1;

    if (!fire) begin
      push.n = 2'd0;
    end else if (two) begin
      push.n = 2'd2;
    end else if (have0 || last) begin
      push.n = 2'd1;
    end else begin
      push.n = 2'd0;
    end

    if (fire) begin
      phase_nxt = last ? PH_IDLE : phase_pre;
      held_nxt  = last ? 8'd0 : held_pre;
    end else begin
      phase_nxt = phase_r;
      held_nxt  = held_r;
    end
  end

  `PCTD_ASSERT(a_held_only_in_digit, (phase_r != PH_DIGIT) |-> (held_r == 8'd0), "held digit outside digit phase")
  `PCTD_ASSERT(a_last_gives_result, (fire && last) |-> (push.n != 2'd0), "end of string without result")
  `PCTD_ASSERT(a_last_to_idle, (fire && last) |=> (phase_r == PH_IDLE), "phase not idle after end of string")

endmodule

@@ src/pctd_outq.sv @@
// Four-entry result queue between the decoder and the output channel.
// Depends on pctd_pkg and percent_decoder_macros.svh.
`include "percent_decoder_macros.svh"

module pctd_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  pctd_pkg::push_t   push,
  output logic              room,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,   // [7:0] out_byte, [8] string_end, [15:9] zero
  output logic              out_tuser,   // has_byte
  output logic              out_tlast    // run_last
);
  import pctd_pkg::*;

  res_t             mem_r [QDEPTH];
  logic [QPTW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNTW-1:0] count_r, count_nxt;
  logic             pop;
  res_t             head;

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (count_r != '0);
  assign room       = (count_r <= QCNTW'(QDEPTH - 2));
  assign head       = mem_r[rd_ptr_r];
  assign out_tdata  = {7'd0, head.string_end, head.out_byte};
  assign out_tuser  = head.has_byte;
  assign out_tlast  = head.run_last;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTW'(push.n);
    rd_ptr_nxt = rd_ptr_r + QPTW'(pop);
    count_nxt  = count_r + QCNTW'(push.n) - QCNTW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_r + QPTW'(1)] <= push.r1;
    end
  end

  `PCTD_NEVER(a_no_overflow, (push.n != 2'd0) && (count_r > QCNTW'(QDEPTH - 2)), "push into full queue")
  `PCTD_NEVER(a_no_underflow, pop && (count_r == '0), "pop from empty queue")
  `PCTD_ASSERT(a_count_bound, count_r <= QCNTW'(QDEPTH), "queue count out of range")

endmodule

@@ src/percent_decoder.sv @@
// An accepted input item is held in the input register stage until the queue
// has room; its first result item is then offered from the result queue.
// Throughput: one input item per cycle while the result queue holds at most two
// items. Input stalls while it holds three or four. A broken escape followed by a
// plain byte yields two result items, which leave one per cycle. So a run of such
// items, or a stalled result channel, slows the input to the result drain rate.
// Reset (rst_n low, synchronous): input stage and queue empty, phase idle,
// held digit cleared. Queue contents are not cleared and need not be.
module percent_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  input  logic        in_tlast,    // is_last
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] out_byte, [8] string_end, [15:9] zero
  output logic        out_tuser,   // has_byte
  output logic        out_tlast    // run_last
);
  import pctd_pkg::*;

  // input register stage
  logic       s1_valid_r;
  logic [7:0] s1_data_r;
  logic       s1_last_r;

  logic       room;
  logic       fire;
  push_t      push;

  // The registered item is decoded only when the queue can take both
  // possible results; the stage refills in the same cycle it drains.
  assign fire      = s1_valid_r && room;
  assign in_tready = !s1_valid_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_data_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // escape state machine and result formation
  pctd_dec u_dec (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .data  (s1_data_r),
    .last  (s1_last_r),
    .push  (push)
  );

  // result queue, also the output register
  pctd_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for percent_decoder: directed and random encoded strings,
// decoded results predicted in the bench and compared item by item.
// Depends on pctd_pkg (phase_t, res_t, PCT_CHAR) and the percent_decoder RTL.
module tb_top;
  import pctd_pkg::*;

  // cycles with no item moving on either channel before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  // settle time after the last expected result
  localparam int TAIL_CYCLES = 10;
  // chance, in percent, that a side idles in a given cycle
  localparam int IDLE_PCT = 17;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] in_byte
  logic        in_tlast;    // is_last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;   // [7:0] out_byte, [8] string_end, [15:9] zero
  logic        out_tuser;   // has_byte
  logic        out_tlast;   // run_last

  // decoder state as the bench sees it
  phase_t     dec_phase;
  logic [7:0] held_char;

  res_t decoded_q[$];       // decoded results still owed by the block
  int   mismatches = 0;
  int   items_sent = 0;
  int   quiet_cycles = 0;
  bit   steady_flow = 0;    // when set, neither side idles

  percent_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Hex helpers, own versions
  // ---------------------------------------------------------------------------
  function automatic bit is_hex_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return 4'(c - 8'h30);
    if (c inside {[8'h41:8'h46]}) return 4'(c - 8'h41 + 8'd10);
    if (c inside {[8'h61:8'h66]}) return 4'(c - 8'h61 + 8'd10);
    return 4'd0;
  endfunction

  // random hex digit, either case
  function automatic logic [7:0] any_hex_char();
    int pick;
    pick = $urandom_range(21);
    if (pick < 10) return 8'(8'h30 + pick);
    if (pick < 16) return 8'(8'h41 + pick - 10);
    return 8'(8'h61 + pick - 16);
  endfunction

  function automatic logic [7:0] any_non_hex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (is_hex_digit(c));
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Decoder prediction: one accepted item in, up to two decoded results queued
  // ---------------------------------------------------------------------------
  task automatic predict_decode(input logic [7:0] b, input logic last);
    logic [7:0] bytes_out [2];
    int         n;
    bit         as_plain;
    res_t       r;
    n = 0;
    as_plain = 1'b0;
    case (dec_phase)
      PH_PCT: begin
        if (is_hex_digit(b)) begin
          held_char = b;
          dec_phase = PH_DIGIT;
        end else begin
          as_plain = 1'b1;    // lone '%' dropped, byte reparsed
        end
      end
      PH_DIGIT: begin
        if (is_hex_digit(b)) begin
          bytes_out[n] = {digit_value(held_char), digit_value(b)};
          n = n + 1;
          dec_phase = PH_IDLE;
        end else begin
          bytes_out[n] = held_char;   // broken pair: held digit goes out as data
          n = n + 1;
          as_plain = 1'b1;
        end
        held_char = 8'h00;
      end
      default: as_plain = 1'b1;
    endcase
    if (as_plain) begin
      if (b == PCT_CHAR) begin
        dec_phase = PH_PCT;
      end else begin
        dec_phase = PH_IDLE;
        bytes_out[n] = b;
        n = n + 1;
      end
    end
    // end of string flushes a held digit; a pending '%' just vanishes
    if (last) begin
      if (dec_phase == PH_DIGIT) begin
        bytes_out[n] = held_char;
        n = n + 1;
      end
      dec_phase = PH_IDLE;
      held_char = 8'h00;
    end
    if (n == 0) begin
      if (last) begin
        r = '{out_byte: 8'h00, has_byte: 1'b0, string_end: 1'b1, run_last: 1'b1};
        decoded_q.push_back(r);
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        r.out_byte   = bytes_out[i];
        r.has_byte   = 1'b1;
        r.string_end = last && (i == n - 1);
        r.run_last   = (i == n - 1);
        decoded_q.push_back(r);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side: drive at the falling edge, handshake seen at the rising edge
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [7:0] b, input logic last);
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_decode(b, last);
    items_sent++;
  endtask

  // drop valid so the last item is not taken twice
  task automatic hold_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1);
  endtask

  // one string built mostly from valid escapes and plain bytes, with some
  // broken or unfinished escapes mixed in; the final byte carries last
  task automatic send_random_string();
    logic [7:0] chars [$];
    int         tokens;
    int         kind;
    tokens = $urandom_range(1, 6);
    for (int t = 0; t < tokens; t++) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        chars.push_back(PCT_CHAR);
        chars.push_back(any_hex_char());
        chars.push_back(any_hex_char());
      end else if (kind < 75) begin
        chars.push_back(8'($urandom_range(255)));
      end else if (kind < 85) begin
        chars.push_back(PCT_CHAR);
        chars.push_back(any_non_hex_char());
      end else if (kind < 95) begin
        chars.push_back(PCT_CHAR);
        chars.push_back(any_hex_char());
        chars.push_back(any_non_hex_char());
      end else begin
        // unfinished escape, possibly cut by the end of the string
        chars.push_back(PCT_CHAR);
        if ($urandom_range(1)) chars.push_back(any_hex_char());
      end
    end
    foreach (chars[i]) send_item(chars[i], i == chars.size() - 1);
  endtask

  task automatic wait_drained();
    hold_input();
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and the checker
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_tready <= steady_flow ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result item: tdata=%h tuser=%b tlast=%b",
               out_tdata, out_tuser, out_tlast);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        if (out_tdata[7:0] !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, out_tdata[7:0]);
          mismatches++;
        end
        if (out_tuser !== want.has_byte) begin
          $error("has_byte: expected %b, got %b", want.has_byte, out_tuser);
          mismatches++;
        end
        if (out_tdata[8] !== want.string_end) begin
          $error("string_end: expected %b, got %b", want.string_end, out_tdata[8]);
          mismatches++;
        end
        if (out_tlast !== want.run_last) begin
          $error("run_last: expected %b, got %b", want.run_last, out_tlast);
          mismatches++;
        end
        if (out_tdata[15:9] !== 7'd0) begin
          $error("tdata pad: expected %h, got %h", 7'd0, out_tdata[15:9]);
          mismatches++;
        end
      end
    end
  end

  // watchdog: nothing moving on either channel for too long means a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // field extremes, both letter cases, hex range edges and every broken form
  task automatic test_directed();
    send_item(8'h00, 1'b0);   // zero is plain data
    send_item(8'hFF, 1'b1);
    send_text("%4a%F0");      // lower and upper case escapes
    send_text("%%41");        // '%' right after '%': first one dropped
    send_text("%4/%G:");      // pair broken after a digit, then after '%'
    send_text("%");           // lone '%' at end: bare end marker
    send_text("%b");          // held digit flushed at end of string
    send_text("%`g");         // just outside the hex ranges
  endtask

  task automatic test_random_strings(input int item_target);
    while (items_sent < item_target) send_random_string();
  endtask

  // long run at full rate on both sides
  task automatic test_steady_stretch(input int item_count);
    int stop_at;
    stop_at = items_sent + item_count;
    steady_flow = 1'b1;
    while (items_sent < stop_at) send_random_string();
    steady_flow = 1'b0;
  endtask

  // sender holds off until every owed result is out, then resumes mid-traffic
  task automatic test_pause_until_drained();
    send_random_string();
    wait_drained();
    send_random_string();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    dec_phase = PH_IDLE;
    held_char = 8'h00;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_strings(400);
    test_pause_until_drained();
    test_steady_stretch(150);
    test_random_strings(950);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
